FILE: rtl/core/csg_pkg.sv
// ----------------------------------------------------------------------------
// csg_pkg
// Widths, limits and sequencer state type shared by the circle span core.
// ----------------------------------------------------------------------------
`default_nettype none

package csg_pkg;

    localparam int RAD_W  = 10;  // radius register
    localparam int ROW_W  = 11;  // signed row coordinate
    localparam int X_W    = 12;  // signed left edge, -2r .. 0
    localparam int MAG_W  = 11;  // squarer operand magnitude
    localparam int SQ_W   = 22;  // square and limit width
    localparam int AREA_W = 23;  // running cell count

    localparam int MAX_RADIUS = 1023;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SQ_R = 6'b000010,
        S_SQ_Y = 6'b000100,
        S_SQ_X = 6'b001000,
        S_TEST = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/core/csg_sq_unit.sv
// ----------------------------------------------------------------------------
// csg_sq_unit
// Shared squarer: one unsigned multiply per cycle, product registered.
// ----------------------------------------------------------------------------
`default_nettype none

module csg_sq_unit (
    input  wire logic                     i_clk,
    input  wire logic [csg_pkg::MAG_W-1:0] i_operand,
    output logic      [csg_pkg::SQ_W-1:0]  o_square
);

    logic [csg_pkg::SQ_W-1:0] r_square;

    always_ff @(posedge i_clk) begin
        r_square <= csg_pkg::SQ_W'(i_operand * i_operand);
    end

    assign o_square = r_square;

endmodule

`default_nettype wire

FILE: rtl/core/circle_span_generator_core.sv
// ----------------------------------------------------------------------------
// circle_span_generator_core
// Filled-circle scanline spans at double horizontal resolution. One input
// word advances one row from y=radius down to y=-radius; the left edge is
// walked one column per cycle against x*x + 4*y*y <= 4*r*r.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  in       | i_valid / o_ready  | i_restart
//  out      | o_valid / i_ready  | o_row, o_span_start, o_span_length,
//           |                    | o_area_so_far, o_last_row
//  cfg      | i_cfg_we           | i_cfg_data (radius)
//
//  From accept a row passes through S_SQ_R, S_SQ_Y, S_SQ_X, then S_TEST once
//  per column tested by the edge walk (at least one), then S_EMIT and back to
//  S_IDLE before the next word is taken. One shared squarer is used for r*r,
//  y*y and each x*x.
//  o_ready is high only while the sequencer is idle. A finished span waits
//  in the output register; the next row may compute meanwhile and holds in
//  the emit step until the register is free.
//  Synchronous active-low reset: radius 0, top row, empty area.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_span_generator_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // config
    input  wire logic                        i_cfg_we,
    input  wire logic [csg_pkg::RAD_W-1:0]   i_cfg_data,
    // input channel
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_restart,
    // output channel
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic signed [csg_pkg::ROW_W-1:0] o_row,
    output logic [csg_pkg::X_W-1:0]          o_span_start,
    output logic [csg_pkg::X_W-1:0]          o_span_length,
    output logic [csg_pkg::AREA_W-1:0]       o_area_so_far,
    output logic                             o_last_row
);

    localparam int RAD_W  = csg_pkg::RAD_W;
    localparam int ROW_W  = csg_pkg::ROW_W;
    localparam int X_W    = csg_pkg::X_W;
    localparam int MAG_W  = csg_pkg::MAG_W;
    localparam int SQ_W   = csg_pkg::SQ_W;
    localparam int AREA_W = csg_pkg::AREA_W;

    csg_pkg::t_state r_state, n_state;

    logic [RAD_W-1:0]         r_radius, n_radius;
    logic signed [ROW_W-1:0]  r_row, n_row;
    logic signed [X_W-1:0]    r_edge, n_edge;
    logic signed [X_W-1:0]    r_x, n_x;
    logic [SQ_W-1:0]          r_lim, n_lim;
    logic [AREA_W-1:0]        r_area, n_area;
    logic                     r_finished, n_finished;

    logic                     r_out_valid, n_out_valid;
    logic signed [ROW_W-1:0]  r_out_row, n_out_row;
    logic [X_W-1:0]           r_out_start, n_out_start;
    logic [X_W-1:0]           r_out_len, n_out_len;
    logic [AREA_W-1:0]        r_out_area, n_out_area;
    logic                     r_out_last, n_out_last;

    logic [MAG_W-1:0]         sq_operand;
    logic [SQ_W-1:0]          sq_result;

    logic                     in_take;
    logic                     out_free;
    logic                     upper;
    logic                     in_disc;
    logic signed [X_W-1:0]    x_next;
    logic signed [X_W-1:0]    x_min;
    logic signed [ROW_W-1:0]  row_bottom;
    logic [ROW_W-1:0]         row_mag;
    logic [X_W-1:0]           edge_mag;
    logic [X_W-1:0]           x_mag;
    logic [X_W-1:0]           x_next_mag;
    logic [X_W-1:0]           span_len;
    logic [RAD_W-1:0]         cfg_radius;

    csg_sq_unit u_sq (
        .i_clk     (i_clk),
        .i_operand (sq_operand),
        .o_square  (sq_result)
    );

    assign o_ready  = (r_state == csg_pkg::S_IDLE);
    assign in_take  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    assign upper      = !r_row[ROW_W-1];
    assign in_disc    = (sq_result <= r_lim);
    assign x_next     = upper ? (r_x - X_W'(1)) : (r_x + X_W'(1));
    assign x_min      = X_W'(0) - X_W'({r_radius, 1'b0});
    assign row_bottom = ROW_W'(0) - ROW_W'(r_radius);
    assign row_mag    = r_row[ROW_W-1] ? (ROW_W'(0) - r_row) : r_row;
    // the edge is never positive, nor is the walk position in S_SQ_X
    assign edge_mag   = X_W'(0) - r_edge;
    assign x_mag      = X_W'(0) - r_x;
    assign x_next_mag = X_W'(0) - x_next;
    assign span_len   = X_W'({edge_mag[X_W-2:0], 1'b1});

    assign cfg_radius = (i_cfg_data > RAD_W'(csg_pkg::MAX_RADIUS))
                        ? RAD_W'(csg_pkg::MAX_RADIUS) : i_cfg_data;

    always_comb begin
        sq_operand = '0;
        case (r_state)
            csg_pkg::S_SQ_R: sq_operand = MAG_W'(r_radius);
            csg_pkg::S_SQ_Y: sq_operand = MAG_W'(row_mag);
            csg_pkg::S_SQ_X: sq_operand = x_mag[MAG_W-1:0];
            csg_pkg::S_TEST: sq_operand = x_next_mag[MAG_W-1:0];
            default:         sq_operand = '0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_radius    = r_radius;
        n_row       = r_row;
        n_edge      = r_edge;
        n_x         = r_x;
        n_lim       = r_lim;
        n_area      = r_area;
        n_finished  = r_finished;
        n_out_valid = r_out_valid && !i_ready;
        n_out_row   = r_out_row;
        n_out_start = r_out_start;
        n_out_len   = r_out_len;
        n_out_area  = r_out_area;
        n_out_last  = r_out_last;

        case (r_state)
            csg_pkg::S_IDLE: begin
                if (i_cfg_we) begin
                    n_radius   = cfg_radius;
                    n_row      = ROW_W'(cfg_radius);
                    n_edge     = '0;
                    n_area     = '0;
                    n_finished = 1'b0;
                end else if (in_take) begin
                    if (i_restart) begin
                        n_row      = ROW_W'(r_radius);
                        n_edge     = '0;
                        n_area     = '0;
                        n_finished = 1'b0;
                        n_state    = csg_pkg::S_SQ_R;
                    end else if (!r_finished) begin
                        n_state = csg_pkg::S_SQ_R;
                    end
                end
            end
            csg_pkg::S_SQ_R: begin
                n_state = csg_pkg::S_SQ_Y;
            end
            csg_pkg::S_SQ_Y: begin
                n_lim   = {sq_result[SQ_W-3:0], 2'b00};   // 4*r*r
                n_x     = r_edge;
                n_state = csg_pkg::S_SQ_X;
            end
            csg_pkg::S_SQ_X: begin
                n_lim   = r_lim - {sq_result[SQ_W-3:0], 2'b00};  // minus 4*y*y
                n_state = csg_pkg::S_TEST;
            end
            csg_pkg::S_TEST: begin
                n_x = x_next;
                if (upper) begin
                    // outward: keep the outermost inside column
                    if (in_disc) begin
                        n_edge = r_x;
                    end
                    if (!in_disc || (r_x == x_min)) begin
                        n_state = csg_pkg::S_EMIT;
                    end
                end else begin
                    // inward: stop at the first inside column
                    n_edge = r_x;
                    if (in_disc || (r_x == '0)) begin
                        n_state = csg_pkg::S_EMIT;
                    end
                end
            end
            csg_pkg::S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_row   = r_row;
                    n_out_start = r_edge + X_W'({r_radius, 1'b0});
                    n_out_len   = span_len;
                    n_out_area  = r_area + AREA_W'(span_len);
                    n_out_last  = (r_row == row_bottom);
                    n_area      = r_area + AREA_W'(span_len);
                    if (r_row == row_bottom) begin
                        n_finished = 1'b1;
                    end else begin
                        n_row = r_row - ROW_W'(1);
                    end
                    n_state = csg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = csg_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= csg_pkg::S_IDLE;
            r_radius    <= '0;
            r_row       <= '0;
            r_edge      <= '0;
            r_area      <= '0;
            r_finished  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_radius    <= n_radius;
            r_row       <= n_row;
            r_edge      <= n_edge;
            r_area      <= n_area;
            r_finished  <= n_finished;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x         <= n_x;
        r_lim       <= n_lim;
        r_out_row   <= n_out_row;
        r_out_start <= n_out_start;
        r_out_len   <= n_out_len;
        r_out_area  <= n_out_area;
        r_out_last  <= n_out_last;
    end

    assign o_valid       = r_out_valid;
    assign o_row         = r_out_row;
    assign o_span_start  = r_out_start;
    assign o_span_length = r_out_len;
    assign o_area_so_far = r_out_area;
    assign o_last_row    = r_out_last;

    // left edge stays within [-2r, 0]
    a_edge_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_edge <= 0) && (r_edge >= x_min))
        else $error("left edge out of range");

    // run is only marked done once the bottom row is reached
    a_finished_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> (r_row == row_bottom))
        else $error("finished flag away from bottom row");

    // a span is always odd and its start never lies past column 2r
    a_span_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_span_length[0] && (o_span_start <= X_W'({r_radius, 1'b0}))))
        else $error("bad span geometry");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks circle_span_generator_core against a cycle-free span predictor.
// Directed runs cover the reset radius, tiny circles, restarts, a radius write
// in the middle of a run, words past the bottom row and one full run at a
// large radius. Random runs then change the radius between phases, with
// random idling on both channels. Every result word is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int ITEM_TARGET    = 1700;
    localparam int FULL_RADIUS    = 400;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [csg_pkg::ROW_W-1:0]  row;
        logic [csg_pkg::X_W-1:0]    start;
        logic [csg_pkg::X_W-1:0]    len;
        logic [csg_pkg::AREA_W-1:0] area;
        logic                       last;
    } t_span;

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             i_cfg_we      = 1'b0;
    logic [csg_pkg::RAD_W-1:0]        i_cfg_data    = '0;
    logic                             i_valid       = 1'b0;
    logic                             i_restart     = 1'b0;
    logic                             i_ready       = 1'b0;
    logic                             o_ready;
    logic                             o_valid;
    logic signed [csg_pkg::ROW_W-1:0] o_row;
    logic [csg_pkg::X_W-1:0]          o_span_start;
    logic [csg_pkg::X_W-1:0]          o_span_length;
    logic [csg_pkg::AREA_W-1:0]       o_area_so_far;
    logic                             o_last_row;

    // predictor state
    longint                     circ_radius;
    longint                     next_row;
    longint                     edge_x;
    logic [csg_pkg::AREA_W-1:0] cells_total;
    bit                         run_done;

    t_span pending_spans[$];
    bit    rst_done      = 1'b0;
    int    gap_max       = 0;
    int    stall_max     = 0;
    int    err_count     = 0;
    int    spans_checked = 0;
    int    words_sent    = 0;
    int    ignored_words = 0;
    int    restarts_sent = 0;
    int    radius_writes = 0;
    int    quiet_cycles  = 0;

    circle_span_generator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_restart     (i_restart),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_row         (o_row),
        .o_span_start  (o_span_start),
        .o_span_length (o_span_length),
        .o_area_so_far (o_area_so_far),
        .o_last_row    (o_last_row)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void rewind_run();
        next_row    = circ_radius;
        edge_x      = 0;
        cells_total = '0;
        run_done    = 1'b0;
    endfunction

    // column x is in the disc when x*x + 4*y*y <= 4*r*r (half-row columns)
    function automatic bit in_disc(input longint x, input longint y);
        return x * x + 4 * y * y <= 4 * circ_radius * circ_radius;
    endfunction

    function automatic bit advance_row(input bit restart, output t_span s);
        longint y;
        longint x;
        longint len;
        longint col;
        s = '0;
        if (restart)
            rewind_run();
        if (run_done)
            return 1'b0;
        y = next_row;
        x = edge_x;
        if (y >= 0) begin
            // upper half: edge moves out while columns stay inside
            while (x >= -2 * circ_radius && in_disc(x, y)) begin
                edge_x = x;
                x--;
            end
        end else begin
            // lower half: edge moves in until the first inside column
            while (x <= 0) begin
                edge_x = x;
                if (in_disc(x, y))
                    break;
                x++;
            end
        end
        len         = 2 * ((edge_x < 0) ? -edge_x : edge_x) + 1;
        col         = edge_x + 2 * circ_radius;
        cells_total = cells_total + len[csg_pkg::AREA_W-1:0];
        s.row       = y[csg_pkg::ROW_W-1:0];
        s.start     = col[csg_pkg::X_W-1:0];
        s.len       = len[csg_pkg::X_W-1:0];
        s.area      = cells_total;
        s.last      = (y == -circ_radius);
        if (s.last)
            run_done = 1'b1;
        else
            next_row = y - 1;
        return 1'b1;
    endfunction

    function automatic void pick_idling();
        case ($urandom_range(3, 0))
            0: begin gap_max = 14; stall_max = 14; end
            1: begin gap_max = 0;  stall_max = 0;  end
            2: begin gap_max = 0;  stall_max = 14; end
            default: begin gap_max = 14; stall_max = 0; end
        endcase
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("ERROR: %s", msg);
    endtask

    task automatic await_results();
        while (pending_spans.size() != 0) @(posedge i_clk);
    endtask

    // Valid is either lowered or given a new word in the step of the last accept.
    task automatic send_word(input bit restart);
        int    gap;
        t_span s;
        gap = $urandom_range(gap_max, 0);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_restart <= restart;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        words_sent++;
        if (restart)
            restarts_sent++;
        if (advance_row(restart, s)) begin
            pending_spans.push_back(s);
        end else begin
            ignored_words++;
        end
    endtask

    task automatic settle_idle();
        i_valid <= 1'b0;
        await_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_radius(input int r);
        settle_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= r[csg_pkg::RAD_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        circ_radius = longint'(r[csg_pkg::RAD_W-1:0]);
        if (circ_radius > csg_pkg::MAX_RADIUS)
            circ_radius = csg_pkg::MAX_RADIUS;
        rewind_run();
        radius_writes++;
    endtask

    // radius from reset, a second word past the single row, then a restart
    task automatic test_radius_zero();
        pick_idling();
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b1);
    endtask

    task automatic test_small_runs();
        pick_idling();
        write_radius(1);
        repeat (4) send_word(1'b0);
        send_word(1'b1);
        send_word(1'b0);
        write_radius(2);
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b0);
        // rewrite in the middle of a run
        write_radius(5);
        send_word(1'b0);
        write_radius(csg_pkg::MAX_RADIUS);
        send_word(1'b1);
        send_word(1'b0);
    endtask

    task automatic test_full_size();
        pick_idling();
        write_radius(FULL_RADIUS);
        while (!run_done) send_word(1'b0);
        send_word(1'b0);
    endtask

    task automatic test_random_runs();
        int pick;
        int r;
        int runs;
        int n;
        while (words_sent < ITEM_TARGET) begin
            pick = $urandom_range(99, 0);
            if (pick < 65)
                r = $urandom_range(12, 0);
            else if (pick < 85)
                r = $urandom_range(80, 13);
            else if (pick < 95)
                r = $urandom_range(csg_pkg::MAX_RADIUS - 1, 81);
            else
                r = (pick < 98) ? csg_pkg::MAX_RADIUS : csg_pkg::MAX_RADIUS - 1;
            pick_idling();
            write_radius(r);
            if (r <= 80) begin
                runs = $urandom_range(3, 1);
                repeat (runs) begin
                    send_word(1'b1);
                    while (!run_done && words_sent < ITEM_TARGET) begin
                        if ($urandom_range(299, 0) == 0) begin
                            i_valid <= 1'b0;
                            @(posedge i_clk);
                            await_results();
                        end
                        send_word($urandom_range(99, 0) < 3);
                    end
                    repeat ($urandom_range(2, 0)) send_word(1'b0);
                end
            end else begin
                // large circles: top rows only, left mid-run by the next write
                n = $urandom_range(60, 10);
                send_word(1'b1);
                repeat (n) send_word($urandom_range(99, 0) < 2);
            end
        end
    endtask

    initial begin : result_checker
        int    stall;
        t_span got;
        t_span want;
        wait (rst_done);
        forever begin
            stall = $urandom_range(stall_max, 0);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (o_valid !== 1'b1) @(posedge i_clk);
            got.row   = o_row;
            got.start = o_span_start;
            got.len   = o_span_length;
            got.area  = o_area_so_far;
            got.last  = o_last_row;
            spans_checked++;
            if (pending_spans.size() == 0) begin
                flag_error($sformatf("unexpected span word: row %0d start %0d len %0d",
                                     $signed(got.row), got.start, got.len));
            end else begin
                want = pending_spans.pop_front();
                if (got.row !== want.row || got.start !== want.start ||
                    got.len !== want.len || got.area !== want.area ||
                    got.last !== want.last)
                    flag_error($sformatf({"span %0d: exp row %0d start %0d len %0d ",
                        "area %0d last %0b, got row %0d start %0d len %0d ",
                        "area %0d last %0b"},
                        spans_checked, $signed(want.row), want.start, want.len,
                        want.area, want.last, $signed(got.row), got.start, got.len,
                        got.area, got.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) === 1'b1 || (o_valid && i_ready) === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles, %0d spans outstanding",
                     quiet_cycles, pending_spans.size());
            $display("tb_top failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : main_sequence
        int waited;
        circ_radius = 0;
        rewind_run();
        repeat (3) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done = 1'b1;

        test_radius_zero();
        test_small_runs();
        test_full_size();
        test_random_runs();

        i_valid <= 1'b0;
        waited  = 0;
        while (pending_spans.size() != 0 && waited < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_spans.size() != 0)
            flag_error($sformatf("%0d expected spans never arrived", pending_spans.size()));

        $display("Run covered %0d span words from %0d input words over %0d radius writes.",
                 spans_checked, words_sent, radius_writes);
        $display("It included %0d restarts and %0d words past the bottom row; %0d errors.",
                 restarts_sent, ignored_words, err_count);
        if (err_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
